// File: rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg: shared types and constants for the box temporal and duplicate filter
// Box layout, table sizes, register indexes, sequencer states and the
// command bundle that drives the box tables.
// ----------------------------------------------------------------------------
`default_nettype none

package bbf_pkg;

   localparam int MAX_BOXES     = 16;
   localparam int COORD_BITS    = 12;
   localparam int IDX_W         = $clog2(MAX_BOXES);
   localparam int CNT_W         = $clog2(MAX_BOXES + 1);
   localparam int AREA_W        = 2 * COORD_BITS;
   localparam int PCT_W         = 7;
   localparam int PROD_W        = AREA_W + PCT_W;
   localparam int STABLE_AREA_W = 25;
   localparam int AREA_CMP_W    = (AREA_W > STABLE_AREA_W) ? AREA_W : STABLE_AREA_W;
   localparam int KEPT_W        = 5;
   localparam int BOX_W         = 4 * COORD_BITS;
   localparam int REQ_DATA_W    = ((BOX_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = ((4 + KEPT_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = STABLE_AREA_W;
   localparam int PCT_SCALE     = 100;

   localparam logic [STABLE_AREA_W-1:0] STABLE_AREA_RESET = STABLE_AREA_W'(1000);
   localparam logic [PCT_W-1:0]         TRACK_PCT_RESET   = PCT_W'(50);
   localparam logic [PCT_W-1:0]         DUP_PCT_RESET     = PCT_W'(60);

   typedef logic [COORD_BITS-1:0] coord_type;

   // Packed so that x sits in the lowest bits, as on the request bus.
   typedef struct packed {
      coord_type h;
      coord_type w;
      coord_type y;
      coord_type x;
   } box_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STABLE_AREA = 2'd0,
      CSR_TRACK_PCT   = 2'd1,
      CSR_DUP_PCT     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_CHECK,
      ST_TRACK,
      ST_STORE,
      ST_DUP,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             rd_en;
      logic             rd_acc;
      logic [IDX_W-1:0] rd_addr;
      logic             bank;
      logic             stab_we;
      logic             acc_we;
      logic [IDX_W-1:0] wr_addr;
   } store_cmd_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } ovl_res_type;

endpackage

`default_nettype wire

// File: rtl/bbf_overlap_unit.sv
// ----------------------------------------------------------------------------
// bbf_overlap_unit: pipelined overlap test shared by both table scans
// Four stages: intersection edges, areas, scaled cross products, compare.
// Accepts one box pair per cycle; answers inter * 100 > pct * min(areas).
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_overlap_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire bbf_pkg::box_type              box_a,
   input  wire bbf_pkg::box_type              box_b,
   input  wire logic [bbf_pkg::AREA_W-1:0]    area_a,
   input  wire logic [bbf_pkg::PCT_W-1:0]     pct,
   output bbf_pkg::ovl_res_type               res
);

   logic [bbf_pkg::COORD_BITS:0]   a_right, b_right, a_bottom, b_bottom;
   logic [bbf_pkg::COORD_BITS:0]   right, bottom, left, top, dx, dy;
   logic [bbf_pkg::COORD_BITS-1:0] iw, ih;
   logic [bbf_pkg::AREA_W-1:0]     min_area;

   logic                           v1_ff, v2_ff, v3_ff;
   logic [bbf_pkg::COORD_BITS-1:0] iw_ff, ih_ff, bw_ff, bh_ff;
   logic [bbf_pkg::AREA_W-1:0]     inter_ff, oarea_ff;
   logic [bbf_pkg::PROD_W-1:0]     lhs_ff, rhs_ff;
   bbf_pkg::ovl_res_type           res_ff;

   always_comb begin
      a_right  = {1'b0, box_a.x} + {1'b0, box_a.w};
      b_right  = {1'b0, box_b.x} + {1'b0, box_b.w};
      a_bottom = {1'b0, box_a.y} + {1'b0, box_a.h};
      b_bottom = {1'b0, box_b.y} + {1'b0, box_b.h};
      left     = (box_a.x > box_b.x) ? {1'b0, box_a.x} : {1'b0, box_b.x};
      top      = (box_a.y > box_b.y) ? {1'b0, box_a.y} : {1'b0, box_b.y};
      right    = (a_right < b_right) ? a_right : b_right;
      bottom   = (a_bottom < b_bottom) ? a_bottom : b_bottom;
      dx       = right - left;
      dy       = bottom - top;
      // An empty intersection in either axis gives zero area.
      if ((right > left) && (bottom > top)) begin
         iw = dx[bbf_pkg::COORD_BITS-1:0];
         ih = dy[bbf_pkg::COORD_BITS-1:0];
      end else begin
         iw = '0;
         ih = '0;
      end
      min_area = (area_a < oarea_ff) ? area_a : oarea_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         res_ff <= '0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         res_ff.valid <= v3_ff;
         res_ff.hit   <= lhs_ff > rhs_ff;
      end
   end

   always_ff @(posedge clock) begin
      iw_ff    <= iw;
      ih_ff    <= ih;
      bw_ff    <= box_b.w;
      bh_ff    <= box_b.h;
      inter_ff <= bbf_pkg::AREA_W'(iw_ff) * bbf_pkg::AREA_W'(ih_ff);
      oarea_ff <= bbf_pkg::AREA_W'(bw_ff) * bbf_pkg::AREA_W'(bh_ff);
      lhs_ff   <= bbf_pkg::PROD_W'(inter_ff) * bbf_pkg::PROD_W'(bbf_pkg::PCT_SCALE);
      rhs_ff   <= bbf_pkg::PROD_W'(pct) * bbf_pkg::PROD_W'(min_area);
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// File: rtl/bbf_box_store.sv
// ----------------------------------------------------------------------------
// bbf_box_store: stable-box and accepted-box tables
// The stable table has two banks; one holds the previous frame, the other
// collects the current one. Reads are registered, one box per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_box_store (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bbf_pkg::store_cmd_type cmd,
   input  wire bbf_pkg::box_type       wr_box,
   output bbf_pkg::box_type            rd_box,
   output logic                        rd_valid
);

   bbf_pkg::box_type stab_mem [2*bbf_pkg::MAX_BOXES];
   bbf_pkg::box_type acc_mem  [bbf_pkg::MAX_BOXES];
   bbf_pkg::box_type rd_box_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.stab_we) begin
         stab_mem[{cmd.bank, cmd.wr_addr}] <= wr_box;
      end
      if (cmd.acc_we) begin
         acc_mem[cmd.wr_addr] <= wr_box;
      end
      // The previous frame lives in the bank that is not being filled.
      if (cmd.rd_en) begin
         rd_box_ff <= cmd.rd_acc ? acc_mem[cmd.rd_addr] : stab_mem[{~cmd.bank, cmd.rd_addr}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
   end

   assign rd_box   = rd_box_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

// File: rtl/box_temporal_and_duplicate_filter.sv
// ----------------------------------------------------------------------------
// box_temporal_and_duplicate_filter: bounding box stability and overlap filter
// Sequencer, configuration registers and response register around the shared
// overlap unit and the box tables.
// ----------------------------------------------------------------------------
// One request at a time: an end-of-frame request goes straight to the
// response step; a box that is large enough skips the scan of the
// previous-frame stable boxes, and the scan of the accepted boxes is skipped
// while the accepted table is empty. Each scan stops early on the first
// match. Each scan reads one table entry per cycle through the table read
// port and feeds the four-stage overlap pipeline. A finished response may
// wait in its output register while the next request is taken; if that
// register still holds an unaccepted response when the next one is ready,
// the sequencer waits in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module box_temporal_and_duplicate_filter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // box_x, box_y, box_w, box_h (lowest bits first)
   input  wire logic [bbf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // kept, was_stable, was_duplicate, table_full, kept_count (lowest bits first)
   output logic [bbf_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // frame_done
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bbf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bbf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam logic [bbf_pkg::CNT_W-1:0] MAX_CNT = bbf_pkg::CNT_W'(bbf_pkg::MAX_BOXES);

   logic [bbf_pkg::STABLE_AREA_W-1:0] stable_area_ff;
   logic [bbf_pkg::PCT_W-1:0]         track_pct_ff, dup_pct_ff;

   bbf_pkg::state_type         state_ff, state_in;
   bbf_pkg::box_type           box_ff, box_in;
   logic                       eof_ff, eof_in;
   logic [bbf_pkg::AREA_W-1:0] barea_ff, barea_in;
   logic                       stable_ff, stable_in;
   logic                       dup_ff, dup_in;
   logic                       full_ff, full_in;
   logic                       kept_ff, kept_in;
   logic [bbf_pkg::CNT_W-1:0]  issue_ff, issue_in;
   logic [bbf_pkg::CNT_W-1:0]  recv_ff, recv_in;
   logic                       hit_ff, hit_in;
   logic                       bank_ff, bank_in;
   logic [bbf_pkg::CNT_W-1:0]  prev_cnt_ff, prev_cnt_in;
   logic [bbf_pkg::CNT_W-1:0]  cur_cnt_ff, cur_cnt_in;
   logic [bbf_pkg::CNT_W-1:0]  acc_cnt_ff, acc_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bbf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_go, rsp_free, big, scanning, scan_end;
   logic [bbf_pkg::CNT_W-1:0]  limit;
   logic [bbf_pkg::PCT_W-1:0]  scan_pct;

   bbf_pkg::store_cmd_type     cmd;
   bbf_pkg::box_type           rd_box;
   logic                       rd_valid;
   bbf_pkg::ovl_res_type       res;

   bbf_box_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_box   (box_ff),
      .rd_box   (rd_box),
      .rd_valid (rd_valid)
   );

   bbf_overlap_unit u_overlap (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid),
      .box_a    (box_ff),
      .box_b    (rd_box),
      .area_a   (barea_ff),
      .pct      (scan_pct),
      .res      (res)
   );

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_area_ff <= bbf_pkg::STABLE_AREA_RESET;
         track_pct_ff   <= bbf_pkg::TRACK_PCT_RESET;
         dup_pct_ff     <= bbf_pkg::DUP_PCT_RESET;
      end else if (csr_valid) begin
         case (bbf_pkg::csr_index_type'(csr_index))
            bbf_pkg::CSR_STABLE_AREA: begin
               stable_area_ff <= csr_data[bbf_pkg::STABLE_AREA_W-1:0];
            end
            bbf_pkg::CSR_TRACK_PCT: begin
               track_pct_ff <= csr_data[bbf_pkg::PCT_W-1:0];
            end
            bbf_pkg::CSR_DUP_PCT: begin
               dup_pct_ff <= csr_data[bbf_pkg::PCT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Shared scan control signals.
   always_comb begin
      req_go   = req_tvalid && (state_ff == bbf_pkg::ST_IDLE);
      rsp_free = !rsp_valid_ff || rsp_tready;
      big      = bbf_pkg::AREA_CMP_W'(barea_ff) > bbf_pkg::AREA_CMP_W'(stable_area_ff);
      scanning = (state_ff == bbf_pkg::ST_TRACK) || (state_ff == bbf_pkg::ST_DUP);
      limit    = (state_ff == bbf_pkg::ST_DUP) ? acc_cnt_ff : prev_cnt_ff;
      scan_pct = (state_ff == bbf_pkg::ST_DUP) ? dup_pct_ff : track_pct_ff;
      // A scan is over once it matched or ran out, and nothing is in flight.
      scan_end = (hit_ff || (recv_ff == limit)) && (recv_ff == issue_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bbf_pkg::ST_IDLE: begin
            if (req_go) begin
               state_in = req_tuser ? bbf_pkg::ST_RESP : bbf_pkg::ST_AREA;
            end
         end
         bbf_pkg::ST_AREA: begin
            state_in = bbf_pkg::ST_CHECK;
         end
         bbf_pkg::ST_CHECK: begin
            if (big) begin
               state_in = bbf_pkg::ST_STORE;
            end else if (prev_cnt_ff == '0) begin
               state_in = bbf_pkg::ST_RESP;
            end else begin
               state_in = bbf_pkg::ST_TRACK;
            end
         end
         bbf_pkg::ST_TRACK: begin
            if (scan_end) begin
               state_in = hit_ff ? bbf_pkg::ST_STORE : bbf_pkg::ST_RESP;
            end
         end
         bbf_pkg::ST_STORE: begin
            state_in = (acc_cnt_ff == '0) ? bbf_pkg::ST_FINISH : bbf_pkg::ST_DUP;
         end
         bbf_pkg::ST_DUP: begin
            if (scan_end) begin
               state_in = bbf_pkg::ST_FINISH;
            end
         end
         bbf_pkg::ST_FINISH: begin
            state_in = bbf_pkg::ST_RESP;
         end
         bbf_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = bbf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bbf_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and table commands.
   always_comb begin
      box_in       = box_ff;
      eof_in       = eof_ff;
      barea_in     = barea_ff;
      stable_in    = stable_ff;
      dup_in       = dup_ff;
      full_in      = full_ff;
      kept_in      = kept_ff;
      issue_in     = issue_ff;
      recv_in      = recv_ff;
      hit_in       = hit_ff;
      bank_in      = bank_ff;
      prev_cnt_in  = prev_cnt_ff;
      cur_cnt_in   = cur_cnt_ff;
      acc_cnt_in   = acc_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      cmd          = '0;
      cmd.bank     = bank_ff;
      cmd.rd_addr  = issue_ff[bbf_pkg::IDX_W-1:0];
      cmd.rd_acc   = (state_ff == bbf_pkg::ST_DUP);
      cmd.rd_en    = scanning && (issue_ff < limit) && !hit_ff;

      if (cmd.rd_en) begin
         issue_in = issue_ff + 1'b1;
      end
      if (res.valid) begin
         recv_in = recv_ff + 1'b1;
         if (res.hit) begin
            hit_in = 1'b1;
         end
      end

      case (state_ff)
         bbf_pkg::ST_IDLE: begin
            if (req_go) begin
               box_in    = bbf_pkg::box_type'(req_tdata[bbf_pkg::BOX_W-1:0]);
               eof_in    = req_tuser;
               stable_in = 1'b0;
               dup_in    = 1'b0;
               full_in   = 1'b0;
               kept_in   = 1'b0;
            end
         end
         bbf_pkg::ST_AREA: begin
            barea_in = bbf_pkg::AREA_W'(box_ff.w) * bbf_pkg::AREA_W'(box_ff.h);
         end
         bbf_pkg::ST_CHECK: begin
            stable_in = big;
            issue_in  = '0;
            recv_in   = '0;
            hit_in    = 1'b0;
         end
         bbf_pkg::ST_TRACK: begin
            if (scan_end) begin
               stable_in = hit_ff;
            end
         end
         bbf_pkg::ST_STORE: begin
            if (cur_cnt_ff < MAX_CNT) begin
               cmd.stab_we = 1'b1;
               cmd.wr_addr = cur_cnt_ff[bbf_pkg::IDX_W-1:0];
               cur_cnt_in  = cur_cnt_ff + 1'b1;
            end else begin
               full_in = 1'b1;
            end
            issue_in = '0;
            recv_in  = '0;
            hit_in   = 1'b0;
         end
         bbf_pkg::ST_DUP: begin
         end
         bbf_pkg::ST_FINISH: begin
            // hit_ff was cleared on the way in when no accepted box existed.
            dup_in  = hit_ff;
            kept_in = !hit_ff;
            if (!hit_ff) begin
               if (acc_cnt_ff < MAX_CNT) begin
                  cmd.acc_we = 1'b1;
                  cmd.wr_addr = acc_cnt_ff[bbf_pkg::IDX_W-1:0];
                  acc_cnt_in  = acc_cnt_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         bbf_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = eof_ff;
               rsp_data_in  = bbf_pkg::RSP_DATA_W'({bbf_pkg::KEPT_W'(acc_cnt_ff),
                                                    full_ff, dup_ff, stable_ff, kept_ff});
               if (eof_ff) begin
                  bank_in     = ~bank_ff;
                  prev_cnt_in = cur_cnt_ff;
                  cur_cnt_in  = '0;
                  acc_cnt_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbf_pkg::ST_IDLE;
         issue_ff     <= '0;
         recv_ff      <= '0;
         hit_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         prev_cnt_ff  <= '0;
         cur_cnt_ff   <= '0;
         acc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         recv_ff      <= recv_in;
         hit_ff       <= hit_in;
         bank_ff      <= bank_in;
         prev_cnt_ff  <= prev_cnt_in;
         cur_cnt_ff   <= cur_cnt_in;
         acc_cnt_ff   <= acc_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      box_ff      <= box_in;
      eof_ff      <= eof_in;
      barea_ff    <= barea_in;
      stable_ff   <= stable_in;
      dup_ff      <= dup_in;
      full_ff     <= full_in;
      kept_ff     <= kept_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == bbf_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
